// ===== design/lifl_pkg.sv =====
// Shared types and constants for the LIF neuron layer step unit.
package lifl_pkg;

    localparam int NEURONS   = 256;
    localparam int NEURON_AW = $clog2(NEURONS);
    localparam int IDX_W     = 8;
    localparam int VAL_W     = 16;
    localparam int DEC_W     = 12;

    localparam logic [DEC_W-1:0] DECAY_RESET  = 12'd3277;
    localparam logic [VAL_W-1:0] THRESH_RESET = 16'd256;

    typedef enum logic [1:0] {
        MODE_STEP  = 2'd0,
        MODE_PARAM = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cur;
        logic signed [VAL_W-1:0] vol;
    } state_t;

    typedef struct packed {
        logic [DEC_W-1:0]        cdec;
        logic [DEC_W-1:0]        vdec;
        logic signed [VAL_W-1:0] th;
    } param_t;

    typedef struct packed {
        logic                    st_we;
        logic                    par_we;
        logic                    spike;
        state_t                  st_new;
        param_t                  par_new;
        logic signed [VAL_W-1:0] out_cur;
        logic signed [VAL_W-1:0] out_vol;
    } upd_t;

    localparam state_t STATE_RESET = '{cur: '0, vol: '0};
    localparam param_t PARAM_RESET = '{cdec: DECAY_RESET, vdec: DECAY_RESET,
                                       th: THRESH_RESET};

endpackage

// ===== design/lifl_ram.sv =====
// Per-neuron storage with one write and one registered read port and per-entry valid bits.
module lifl_ram #(
    parameter int               WIDTH = 32,
    parameter int               DEPTH = 256,
    parameter logic [WIDTH-1:0] INIT  = '0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : INIT;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lifl_update.sv =====
// Neuron update datapath: decay, integrate, saturate, threshold and mode select.
module lifl_update (
    input  logic [1:0]                          mode,
    input  logic [lifl_pkg::IDX_W-1:0]          idx,
    input  logic signed [lifl_pkg::VAL_W-1:0]   in_cur,
    input  logic [lifl_pkg::DEC_W-1:0]          new_cdec,
    input  logic [lifl_pkg::DEC_W-1:0]          new_vdec,
    input  logic signed [lifl_pkg::VAL_W-1:0]   new_th,
    input  lifl_pkg::state_t                    st,
    input  lifl_pkg::param_t                    par,
    input  logic signed [lifl_pkg::VAL_W-1:0]   rest,
    output lifl_pkg::upd_t                      res
);

    logic                  in_range;
    logic signed [28:0]    i_ext;
    logic signed [28:0]    cdec_ext;
    logic signed [28:0]    i_prod;
    logic signed [29:0]    i_rnd;
    logic signed [17:0]    i_scaled;
    logic signed [18:0]    i_sum;
    logic signed [15:0]    cur_step;
    logic signed [16:0]    diff;
    logic signed [29:0]    d_ext;
    logic signed [29:0]    vdec_ext;
    logic signed [29:0]    d_prod;
    logic signed [30:0]    d_rnd;
    logic signed [18:0]    d_scaled;
    logic signed [19:0]    v_sum;
    logic signed [15:0]    vol_sat;
    logic                  fire;

    assign in_range = 32'(idx) < 32'(lifl_pkg::NEURONS);

    assign i_ext    = 29'(st.cur);
    assign cdec_ext = 29'({1'b0, par.cdec});
    assign i_prod   = i_ext * cdec_ext;
    assign i_rnd    = 30'(i_prod) + 30'sd2048;
    assign i_scaled = 18'(i_rnd >>> 12);
    assign i_sum    = 19'(i_scaled) + 19'(in_cur);
    assign cur_step = (i_sum > 19'sd32767)  ? 16'sh7fff :
                      (i_sum < -19'sd32768) ? 16'sh8000 : 16'(i_sum);

    assign diff     = 17'(st.vol) - 17'(rest);
    assign d_ext    = 30'(diff);
    assign vdec_ext = 30'({1'b0, par.vdec});
    assign d_prod   = d_ext * vdec_ext;
    assign d_rnd    = 31'(d_prod) + 31'sd2048;
    assign d_scaled = 19'(d_rnd >>> 12);
    assign v_sum    = 20'(d_scaled) + 20'(cur_step);
    assign vol_sat  = (v_sum > 20'sd32767)  ? 16'sh7fff :
                      (v_sum < -20'sd32768) ? 16'sh8000 : 16'(v_sum);
    assign fire     = vol_sat > par.th;

    always_comb begin
        res.st_we   = 1'b0;
        res.par_we  = 1'b0;
        res.spike   = 1'b0;
        res.st_new  = st;
        res.par_new = par;
        case (mode)
            lifl_pkg::MODE_STEP: begin
                res.st_we      = in_range;
                res.spike      = fire;
                res.st_new.cur = cur_step;
                res.st_new.vol = fire ? rest : vol_sat;
            end
            lifl_pkg::MODE_PARAM: begin
                res.par_we       = in_range;
                res.par_new.cdec = new_cdec;
                res.par_new.vdec = new_vdec;
                res.par_new.th   = new_th;
            end
            lifl_pkg::MODE_CLEAR: begin
                res.st_we      = in_range;
                res.st_new.cur = '0;
                res.st_new.vol = rest;
            end
            default: begin
                res.st_new = st;
            end
        endcase
        if (!in_range) begin
            res.spike = 1'b0;
        end
        res.out_cur = in_range ? res.st_new.cur : '0;
        res.out_vol = in_range ? res.st_new.vol : '0;
    end

endmodule

// ===== design/lif_neuron_layer_step_unit.sv =====
// Top level of the LIF neuron layer step unit: pipeline control, storage and result register.
// An accepted transaction is registered into the update stage, then into the result register.
// Throughput: one transaction per cycle while m_ready does not stall the result register; the state
// read at acceptance and the write at the end of the update stage, with a last-write bypass, set that figure.
// Reset (aresetn low, synchronous): pipeline empties, rest voltage returns to 0 and all
// neurons read back their reset state at once through per-entry valid bits.
module lif_neuron_layer_step_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic signed [lifl_pkg::VAL_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic [lifl_pkg::IDX_W-1:0]          s_neuron_index,
    input  logic signed [lifl_pkg::VAL_W-1:0]   s_input_current,
    input  logic [lifl_pkg::DEC_W-1:0]          s_new_current_decay,
    input  logic [lifl_pkg::DEC_W-1:0]          s_new_voltage_decay,
    input  logic signed [lifl_pkg::VAL_W-1:0]   s_new_threshold,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lifl_pkg::IDX_W-1:0]          m_out_index,
    output logic                                m_spike,
    output logic signed [lifl_pkg::VAL_W-1:0]   m_out_voltage,
    output logic signed [lifl_pkg::VAL_W-1:0]   m_out_current
);

    logic signed [lifl_pkg::VAL_W-1:0] rest_reg;

    logic                              s1_valid_reg;
    logic [1:0]                        s1_mode_reg;
    logic [lifl_pkg::IDX_W-1:0]        s1_idx_reg;
    logic signed [lifl_pkg::VAL_W-1:0] s1_cur_reg;
    logic [lifl_pkg::DEC_W-1:0]        s1_cdec_reg;
    logic [lifl_pkg::DEC_W-1:0]        s1_vdec_reg;
    logic signed [lifl_pkg::VAL_W-1:0] s1_th_reg;

    logic                              lws_valid_reg;
    logic [lifl_pkg::IDX_W-1:0]        lws_idx_reg;
    lifl_pkg::state_t                  lws_data_reg;
    logic                              lwp_valid_reg;
    logic [lifl_pkg::IDX_W-1:0]        lwp_idx_reg;
    lifl_pkg::param_t                  lwp_data_reg;

    logic                              m_valid_reg;
    logic [lifl_pkg::IDX_W-1:0]        m_idx_reg;
    logic                              m_spike_reg;
    logic signed [lifl_pkg::VAL_W-1:0] m_vol_reg;
    logic signed [lifl_pkg::VAL_W-1:0] m_cur_reg;

    logic             advance;
    logic             accept;
    logic             commit;
    lifl_pkg::state_t st_q;
    lifl_pkg::param_t par_q;
    lifl_pkg::state_t st_eff;
    lifl_pkg::param_t par_eff;
    lifl_pkg::upd_t   upd;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign commit  = s1_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_reg <= '0;
        end else if (cfg_wen) begin
            rest_reg <= cfg_wdata;
        end
    end

    lifl_ram #(
        .WIDTH ($bits(lifl_pkg::state_t)),
        .DEPTH (lifl_pkg::NEURONS),
        .INIT  (lifl_pkg::STATE_RESET)
    ) u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (commit && upd.st_we),
        .wr_addr (s1_idx_reg[lifl_pkg::NEURON_AW-1:0]),
        .wr_data (upd.st_new),
        .rd_en   (accept),
        .rd_addr (s_neuron_index[lifl_pkg::NEURON_AW-1:0]),
        .rd_data (st_q)
    );

    lifl_ram #(
        .WIDTH ($bits(lifl_pkg::param_t)),
        .DEPTH (lifl_pkg::NEURONS),
        .INIT  (lifl_pkg::PARAM_RESET)
    ) u_param_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (commit && upd.par_we),
        .wr_addr (s1_idx_reg[lifl_pkg::NEURON_AW-1:0]),
        .wr_data (upd.par_new),
        .rd_en   (accept),
        .rd_addr (s_neuron_index[lifl_pkg::NEURON_AW-1:0]),
        .rd_data (par_q)
    );

    // bypass the entry written at the edge this transaction was accepted
    assign st_eff  = (lws_valid_reg && lws_idx_reg == s1_idx_reg) ? lws_data_reg : st_q;
    assign par_eff = (lwp_valid_reg && lwp_idx_reg == s1_idx_reg) ? lwp_data_reg : par_q;

    lifl_update u_update (
        .mode     (s1_mode_reg),
        .idx      (s1_idx_reg),
        .in_cur   (s1_cur_reg),
        .new_cdec (s1_cdec_reg),
        .new_vdec (s1_vdec_reg),
        .new_th   (s1_th_reg),
        .st       (st_eff),
        .par      (par_eff),
        .rest     (rest_reg),
        .res      (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg <= s_mode;
            s1_idx_reg  <= s_neuron_index;
            s1_cur_reg  <= s_input_current;
            s1_cdec_reg <= s_new_current_decay;
            s1_vdec_reg <= s_new_voltage_decay;
            s1_th_reg   <= s_new_threshold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lws_valid_reg <= 1'b0;
            lwp_valid_reg <= 1'b0;
        end else begin
            if (commit && upd.st_we) begin
                lws_valid_reg <= 1'b1;
            end
            if (commit && upd.par_we) begin
                lwp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && upd.st_we) begin
            lws_idx_reg  <= s1_idx_reg;
            lws_data_reg <= upd.st_new;
        end
        if (commit && upd.par_we) begin
            lwp_idx_reg  <= s1_idx_reg;
            lwp_data_reg <= upd.par_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_idx_reg   <= s1_idx_reg;
            m_spike_reg <= upd.spike;
            m_vol_reg   <= upd.out_vol;
            m_cur_reg   <= upd.out_cur;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_index   = m_idx_reg;
    assign m_spike       = m_spike_reg;
    assign m_out_voltage = m_vol_reg;
    assign m_out_current = m_cur_reg;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("update stage lost its transaction while stalled");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a transaction in the update stage");

    a_bypass_track: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && upd.st_we |=> lws_valid_reg && lws_idx_reg == $past(s1_idx_reg))
        else $error("state bypass does not track the last write");

    a_accept_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s1_valid_reg |-> commit)
        else $error("transaction accepted over an occupied update stage");
`endif

endmodule

// ===== test/lif_neuron_layer_step_unit_test.sv =====
// Testbench for lif_neuron_layer_step_unit: directed and random neuron updates.
module lif_neuron_layer_step_unit_test;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         IDLE_PCT     = 27;
    localparam int         RANDOM_ITEMS = 1850;
    localparam int         HOT_COUNT    = 6;

    typedef struct packed {
        logic [lifl_pkg::IDX_W-1:0]        index;
        logic                              spike;
        logic signed [lifl_pkg::VAL_W-1:0] voltage;
        logic signed [lifl_pkg::VAL_W-1:0] current;
    } neuron_result_t;

    logic                              aclk                = 1'b0;
    logic                              aresetn             = 1'b0;
    logic                              cfg_wen             = 1'b0;
    logic signed [lifl_pkg::VAL_W-1:0] cfg_wdata           = '0;
    logic                              s_valid             = 1'b0;
    logic                              s_ready;
    logic [1:0]                        s_mode              = lifl_pkg::MODE_STEP;
    logic [lifl_pkg::IDX_W-1:0]        s_neuron_index      = '0;
    logic signed [lifl_pkg::VAL_W-1:0] s_input_current     = '0;
    logic [lifl_pkg::DEC_W-1:0]        s_new_current_decay = '0;
    logic [lifl_pkg::DEC_W-1:0]        s_new_voltage_decay = '0;
    logic signed [lifl_pkg::VAL_W-1:0] s_new_threshold     = '0;
    logic                              m_valid;
    logic                              m_ready             = 1'b0;
    logic [lifl_pkg::IDX_W-1:0]        m_out_index;
    logic                              m_spike;
    logic signed [lifl_pkg::VAL_W-1:0] m_out_voltage;
    logic signed [lifl_pkg::VAL_W-1:0] m_out_current;

    logic signed [lifl_pkg::VAL_W-1:0] syn_cur [lifl_pkg::NEURONS];
    logic signed [lifl_pkg::VAL_W-1:0] mem_vol [lifl_pkg::NEURONS];
    logic [lifl_pkg::DEC_W-1:0]        cur_dec [lifl_pkg::NEURONS];
    logic [lifl_pkg::DEC_W-1:0]        vol_dec [lifl_pkg::NEURONS];
    logic signed [lifl_pkg::VAL_W-1:0] thresh  [lifl_pkg::NEURONS];
    logic signed [lifl_pkg::VAL_W-1:0] rest_v;

    neuron_result_t pending_results [$];
    int             error_count = 0;
    logic           idle_en     = 1'b1;

    lif_neuron_layer_step_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wen             (cfg_wen),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_neuron_index      (s_neuron_index),
        .s_input_current     (s_input_current),
        .s_new_current_decay (s_new_current_decay),
        .s_new_voltage_decay (s_new_voltage_decay),
        .s_new_threshold     (s_new_threshold),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_index         (m_out_index),
        .m_spike             (m_spike),
        .m_out_voltage       (m_out_voltage),
        .m_out_current       (m_out_current)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int sat_q88(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // round half up: floor((v * dec + 2048) / 4096)
    function automatic int decay_scale(input int v, input logic [lifl_pkg::DEC_W-1:0] dec);
        int p;
        p = v * int'(dec) + 2048;
        return p >>> 12;
    endfunction

    function automatic neuron_result_t update_neuron(input logic [1:0] mode,
            input logic [lifl_pkg::IDX_W-1:0] idx,
            input logic signed [lifl_pkg::VAL_W-1:0] x,
            input logic [lifl_pkg::DEC_W-1:0] cdec, input logic [lifl_pkg::DEC_W-1:0] vdec,
            input logic signed [lifl_pkg::VAL_W-1:0] th);
        neuron_result_t r;
        int             cur_n;
        int             vol_n;
        int             diff;
        r.index = idx;
        r.spike = 1'b0;
        if (int'(idx) >= lifl_pkg::NEURONS) begin
            r.voltage = '0;
            r.current = '0;
            return r;
        end
        case (mode)
            lifl_pkg::MODE_STEP: begin
                cur_n = sat_q88(decay_scale(int'(syn_cur[idx]), cur_dec[idx]) + int'(x));
                diff  = int'(mem_vol[idx]) - int'(rest_v);
                vol_n = sat_q88(decay_scale(diff, vol_dec[idx]) + cur_n);
                if (vol_n > int'(thresh[idx])) begin
                    r.spike = 1'b1;
                    vol_n   = int'(rest_v);
                end
                syn_cur[idx] = cur_n[lifl_pkg::VAL_W-1:0];
                mem_vol[idx] = vol_n[lifl_pkg::VAL_W-1:0];
            end
            lifl_pkg::MODE_PARAM: begin
                cur_dec[idx] = cdec;
                vol_dec[idx] = vdec;
                thresh[idx]  = th;
            end
            lifl_pkg::MODE_CLEAR: begin
                syn_cur[idx] = '0;
                mem_vol[idx] = rest_v;
            end
            default: ;
        endcase
        r.voltage = mem_vol[idx];
        r.current = syn_cur[idx];
        return r;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [lifl_pkg::IDX_W-1:0] idx,
            input logic signed [lifl_pkg::VAL_W-1:0] x,
            input logic [lifl_pkg::DEC_W-1:0] cdec, input logic [lifl_pkg::DEC_W-1:0] vdec,
            input logic signed [lifl_pkg::VAL_W-1:0] th);
        int gap = 0;
        while (idle_en && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_mode              <= mode;
        s_neuron_index      <= idx;
        s_input_current     <= x;
        s_new_current_decay <= cdec;
        s_new_voltage_decay <= vdec;
        s_new_threshold     <= th;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(update_neuron(mode, idx, x, cdec, vdec, th));
    endtask

    task automatic send_step(input logic [lifl_pkg::IDX_W-1:0] idx,
            input logic signed [lifl_pkg::VAL_W-1:0] x);
        send_item(lifl_pkg::MODE_STEP, idx, x, '0, '0, '0);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_rest(input logic signed [lifl_pkg::VAL_W-1:0] v);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        rest_v  = v;
    endtask

    task automatic test_reset_state();
        send_step(8'd0, 16'sd0);
        send_step(8'd255, 16'sd32767);
        send_step(8'd255, 16'sd32767);
        send_step(8'd128, -16'sd32768);
        send_step(8'd128, -16'sd32768);
    endtask

    task automatic test_spike_and_reset();
        send_step(8'd1, 16'sd512);
        send_step(8'd1, 16'sd0);
    endtask

    task automatic test_param_write();
        send_item(lifl_pkg::MODE_PARAM, 8'd2, 16'sd0, 12'd4095, 12'd4095, 16'sd32767);
        send_step(8'd2, -16'sd32768);
        send_item(lifl_pkg::MODE_PARAM, 8'd3, -16'sd1, 12'd0, 12'd0, -16'sd32768);
        send_step(8'd3, 16'sd0);
    endtask

    task automatic test_clear_and_rest();
        set_rest(-16'sd32768);
        send_step(8'd255, 16'sd0);
        send_item(lifl_pkg::MODE_CLEAR, 8'd255, 16'sd0, '0, '0, '0);
        send_step(8'd4, 16'sd0);
        set_rest(16'sd32767);
        send_step(8'd4, 16'sd0);
        send_item(lifl_pkg::MODE_CLEAR, 8'd5, 16'sd0, '0, '0, '0);
    endtask

    task automatic test_unused_mode();
        send_item(MODE_UNUSED, 8'd255, 16'sd1234, 12'hfff, 12'hfff, 16'sd1);
        send_item(MODE_UNUSED, 8'd0, 16'sd0, '0, '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        logic [lifl_pkg::IDX_W-1:0]        hot [HOT_COUNT];
        logic [1:0]                        mode;
        logic [lifl_pkg::IDX_W-1:0]        idx;
        logic signed [lifl_pkg::VAL_W-1:0] x;
        logic signed [lifl_pkg::VAL_W-1:0] th;
        logic [lifl_pkg::DEC_W-1:0]        cdec;
        logic [lifl_pkg::DEC_W-1:0]        vdec;
        int                                pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_rest(16'($urandom));
                1: set_rest(-16'sd256);
                2: set_rest(16'sd32767);
                3: set_rest(-16'sd32768);
                default: set_rest(16'sd0);
            endcase
            // hold ready high and valid back to back for one whole phase
            idle_en = (phase != 2);
            foreach (hot[k]) hot[k] = 8'($urandom_range(255));
            repeat (count / 5) begin
                pick = $urandom_range(99);
                if (pick < 78) mode = lifl_pkg::MODE_STEP;
                else if (pick < 88) mode = lifl_pkg::MODE_PARAM;
                else if (pick < 96) mode = lifl_pkg::MODE_CLEAR;
                else mode = MODE_UNUSED;
                if ($urandom_range(99) < 80) idx = hot[$urandom_range(HOT_COUNT-1)];
                else idx = 8'($urandom_range(255));
                if ($urandom_range(99) < 65) x = 16'(int'($urandom_range(900)) - 200);
                else x = 16'($urandom);
                if ($urandom_range(1)) begin
                    cdec = 12'($urandom);
                    vdec = 12'($urandom);
                end else begin
                    cdec = 12'd3000 + 12'($urandom_range(1095));
                    vdec = 12'd3000 + 12'($urandom_range(1095));
                end
                if ($urandom_range(1)) th = 16'($urandom_range(1500));
                else th = 16'($urandom);
                send_item(mode, idx, x, cdec, vdec, th);
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            m_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        neuron_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected transaction: index %0d", m_out_index);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_out_index !== want.index) begin
                        $error("out_index: expected %0d, got %0d", want.index, m_out_index);
                        error_count++;
                    end
                    if (m_spike !== want.spike) begin
                        $error("spike: expected %0d, got %0d", want.spike, m_spike);
                        error_count++;
                    end
                    if (m_out_voltage !== want.voltage) begin
                        $error("out_voltage: expected %0d, got %0d", want.voltage,
                               m_out_voltage);
                        error_count++;
                    end
                    if (m_out_current !== want.current) begin
                        $error("out_current: expected %0d, got %0d", want.current,
                               m_out_current);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        #400000;
        $display("lif_neuron_layer_step_unit test failed");
        $finish;
    end

    initial begin
        for (int k = 0; k < lifl_pkg::NEURONS; k++) begin
            syn_cur[k] = lifl_pkg::STATE_RESET.cur;
            mem_vol[k] = lifl_pkg::STATE_RESET.vol;
            cur_dec[k] = lifl_pkg::PARAM_RESET.cdec;
            vol_dec[k] = lifl_pkg::PARAM_RESET.vdec;
            thresh[k]  = lifl_pkg::PARAM_RESET.th;
        end
        rest_v = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_spike_and_reset();
        test_param_write();
        test_clear_and_rest();
        test_unused_mode();
        test_random_traffic(RANDOM_ITEMS);
        wait_idle();
        if (error_count == 0) begin
            $display("lif_neuron_layer_step_unit test passed");
        end else begin
            $display("lif_neuron_layer_step_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/lifl_pkg.sv
design/lifl_ram.sv
design/lifl_update.sv
design/lif_neuron_layer_step_unit.sv
test/lif_neuron_layer_step_unit_test.sv
